// File: src/spc_pkg.sv
// Package for the stack permutation checker.
// Holds the sizes, the memory request and result types and the shared constants.
// No dependencies.
package spc_pkg;

  localparam int MAX_CARS = 1024;
  localparam int CAR_W    = 11;
  localparam int CAR_MAX  = (1 << CAR_W) - 1;
  localparam int ADDR_W   = $clog2(MAX_CARS);
  localparam int CNT_W    = $clog2(MAX_CARS + 1);
  localparam int NU_W     = CAR_W + 1;

  localparam logic [CAR_W-1:0] CAR_CAP = CAR_W'((MAX_CARS > CAR_MAX) ? CAR_MAX : MAX_CARS);
  localparam logic [CAR_W-1:0] CARS_RESET = CAR_W'(1024);

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CAR_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic valid;
    logic possible;
  } result_t;

endpackage

// File: src/spc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package dependencies.
module spc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/spc_ctrl.sv
// Sequencer of the stack permutation checker: takes cars, pushes and pops the stack memory.
// Depends on spc_pkg for sizes and the memory request and result types.
module spc_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spc_pkg::CAR_W-1:0]     car_number,
  input  logic                          last_car,
  input  logic [spc_pkg::CAR_W-1:0]     eff_cars,
  input  logic                          slot_free,
  output spc_pkg::ram_req_t             ram_req,
  input  logic [spc_pkg::CAR_W-1:0]     ram_rdata,
  output spc_pkg::result_t              res
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PUSH  = 4'b0010,
    S_CHECK = 4'b0100,
    S_HOLD  = 4'b1000
  } state_t;

  state_t                    state, state_next;
  logic [spc_pkg::CAR_W-1:0] car, car_next;
  logic                      last, last_next;
  logic [spc_pkg::CNT_W-1:0] depth, depth_next;
  logic [spc_pkg::NU_W-1:0]  next_unused, next_unused_next;
  logic                      failed, failed_next;
  logic [spc_pkg::CNT_W-1:0] depth_m1;
  logic [spc_pkg::NU_W-1:0]  car_ext;
  logic [spc_pkg::NU_W-1:0]  in_ext;
  logic [spc_pkg::NU_W-1:0]  eff_plus1;

  assign depth_m1  = depth - spc_pkg::CNT_W'(1);
  assign car_ext   = {1'b0, car};
  assign in_ext    = {1'b0, car_number};
  assign eff_plus1 = {1'b0, eff_cars} + spc_pkg::NU_W'(1);
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    logic fin;
    fin              = 1'b0;
    state_next       = state;
    car_next         = car;
    last_next        = last;
    depth_next       = depth;
    next_unused_next = next_unused;
    failed_next      = failed;
    ram_req.we       = 1'b0;
    ram_req.waddr    = depth[spc_pkg::ADDR_W-1:0];
    ram_req.wdata    = next_unused[spc_pkg::CAR_W-1:0];
    ram_req.raddr    = depth_m1[spc_pkg::ADDR_W-1:0];
    res.valid        = 1'b0;
    res.possible     = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          car_next  = car_number;
          last_next = last_car;
          if (failed) begin
            state_next = S_HOLD;
          end else if (car_number == '0 || car_number > eff_cars) begin
            failed_next = 1'b1;
            state_next  = S_HOLD;
          end else if (in_ext >= next_unused) begin
            state_next = S_PUSH;
          end else if (depth == '0) begin
            failed_next = 1'b1;
            state_next  = S_HOLD;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_PUSH: begin
        if (next_unused < car_ext) begin
          if (depth == spc_pkg::CNT_W'(spc_pkg::MAX_CARS)) begin
            failed_next = 1'b1;
            fin         = 1'b1;
          end else begin
            ram_req.we       = 1'b1;
            depth_next       = depth + spc_pkg::CNT_W'(1);
            next_unused_next = next_unused + spc_pkg::NU_W'(1);
          end
        end else begin
          next_unused_next = car_ext + spc_pkg::NU_W'(1);
          fin              = 1'b1;
        end
      end
      S_CHECK: begin
        if (ram_rdata == car) begin
          depth_next = depth_m1;
        end else begin
          failed_next = 1'b1;
        end
        fin = 1'b1;
      end
      S_HOLD: begin
        fin = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fin) begin
      if (!last) begin
        state_next = S_IDLE;
      end else if (slot_free) begin
        res.valid        = 1'b1;
        res.possible     = !failed_next && depth_next == '0 && next_unused_next == eff_plus1;
        depth_next       = '0;
        next_unused_next = spc_pkg::NU_W'(1);
        failed_next      = 1'b0;
        state_next       = S_IDLE;
      end else begin
        state_next = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      depth       <= '0;
      next_unused <= spc_pkg::NU_W'(1);
      failed      <= 1'b0;
    end else begin
      state       <= state_next;
      depth       <= depth_next;
      next_unused <= next_unused_next;
      failed      <= failed_next;
    end
    car  <= car_next;
    last <= last_next;
  end

endmodule

// File: src/stack_permutation_check_core.sv
// Top level of the stack permutation checker: configuration register, result register.
// Instantiates spc_ctrl and spc_ram; depends on spc_pkg.
//
//   Channel  Direction  Handshake            Payload
//   cfg      in         cfg_write            cfg_data (num_cars)
//   in       in         in_valid / in_stall  car_number, last_car
//   out      out        out_valid / out_stall possible
//
// A popped, rejected or post-failure car goes from S_IDLE to S_CHECK or S_HOLD and back.
// A car that pushes k waiting cars stays in S_PUSH, one stack memory write per cycle.
// Over a full sequence of N cars at most N pushes occur.
// Reset is synchronous and needs no clearing pass; the stack is read only below its depth.
// A stalled result holds the block only at the last car of a sequence.
module stack_permutation_check_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [spc_pkg::CAR_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [spc_pkg::CAR_W-1:0] car_number,
  input  logic                      last_car,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      possible
);

  logic [spc_pkg::CAR_W-1:0] num_cars;
  logic [spc_pkg::CAR_W-1:0] eff_cars;
  logic                      slot_free;
  spc_pkg::ram_req_t         ram_req;
  logic [spc_pkg::CAR_W-1:0] ram_rdata;
  spc_pkg::result_t          res;

  assign eff_cars  = (num_cars > spc_pkg::CAR_CAP) ? spc_pkg::CAR_CAP : num_cars;
  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cars  <= spc_pkg::CARS_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        num_cars <= cfg_data;
      end
      if (res.valid) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (res.valid) begin
      possible <= res.possible;
    end
  end

  spc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .car_number (car_number),
    .last_car   (last_car),
    .eff_cars   (eff_cars),
    .slot_free  (slot_free),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .res        (res)
  );

  spc_ram #(
    .WIDTH (spc_pkg::CAR_W),
    .DEPTH (spc_pkg::MAX_CARS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (!out_valid || !out_stall))
    else $error("A new result was loaded over one still waiting to be taken.");

  a_push_busy: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> in_stall)
    else $error("A stack write happened while a new transaction could be accepted.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("The block accepted a transaction without going busy.");

endmodule

// File: tb/tb_stack_permutation_check_core.sv
// Testbench for stack_permutation_check_core: feeds car orders and checks each verdict.
// Sequences are built from random stack routings, some of them damaged on purpose.
// Depends on spc_pkg and on the core and its submodules.
`timescale 1ns / 1ps

module tb_stack_permutation_check_core;

  localparam int SETTLE_CYCLES = 1100;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [spc_pkg::CAR_W-1:0] car;
    logic                      last;
  } car_item_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [spc_pkg::CAR_W-1:0] cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [spc_pkg::CAR_W-1:0] car_number = '0;
  logic                      last_car = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      possible;

  car_item_t car_q[$];
  logic      verdict_q[$];
  logic      car_taken = 1'b0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  bit        pressure_go = 1'b0;
  bit        hold_on = 1'b0;
  int        cars_sent = 0;
  int        mismatches = 0;

  // Predicted state of the checker.
  logic [spc_pkg::CAR_W-1:0] cars_cfg = spc_pkg::CARS_RESET;
  logic [spc_pkg::CAR_W-1:0] siding [spc_pkg::MAX_CARS];
  int                        siding_depth = 0;
  int                        next_free = 1;
  bit                        derailed = 1'b0;

  stack_permutation_check_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .car_number(car_number),
    .last_car  (last_car),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .possible  (possible)
  );

  always #10 clk = ~clk;

  function automatic void route_car(input logic [spc_pkg::CAR_W-1:0] car, input logic last,
                                    output bit has_verdict, output logic verdict);
    int n;
    int c;
    n = (int'(cars_cfg) > spc_pkg::MAX_CARS) ? spc_pkg::MAX_CARS : int'(cars_cfg);
    c = int'(car);
    has_verdict = 1'b0;
    verdict = 1'b0;
    if (!derailed) begin
      if (c < 1 || c > n) begin
        derailed = 1'b1;
      end else if (c >= next_free) begin
        while (next_free < c && !derailed) begin
          if (siding_depth >= spc_pkg::MAX_CARS) begin
            derailed = 1'b1;
          end else begin
            siding[siding_depth] = spc_pkg::CAR_W'(next_free);
            siding_depth++;
            next_free++;
          end
        end
        if (!derailed) next_free = c + 1;
      end else if (siding_depth > 0 && siding[siding_depth-1] == car) begin
        siding_depth--;
      end else begin
        derailed = 1'b1;
      end
    end
    if (last) begin
      has_verdict = 1'b1;
      verdict = !derailed && siding_depth == 0 && next_free == n + 1;
      siding_depth = 0;
      next_free = 1;
      derailed = 1'b0;
    end
  endfunction

  always @(negedge clk) begin
    car_item_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || car_taken) begin
      if (car_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        item = car_q.pop_front();
        in_valid <= 1'b1;
        car_number <= item.car;
        last_car <= item.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_on || ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    bit   has_verdict;
    logic verdict;
    logic want;
    if (rst) begin
      car_taken <= 1'b0;
    end else begin
      car_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        route_car(car_number, last_car, has_verdict, verdict);
        if (has_verdict) verdict_q.insert(verdict_q.size(), verdict);
      end
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $error("possible: expected no transaction, got %0b", possible);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          if (possible !== want) begin
            $error("possible: expected %0b, got %0b", want, possible);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    wait (pressure_go);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  task automatic queue_car(input int car, input bit last);
    car_item_t item;
    item.car = spc_pkg::CAR_W'(car);
    item.last = last;
    car_q.insert(car_q.size(), item);
    cars_sent++;
  endtask

  task automatic wait_idle();
    while (car_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_cars(input logic [spc_pkg::CAR_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    cars_cfg = value;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_sequence(input int n);
    int order[$];
    int pile[$];
    int next_in;
    int roll;
    int i;
    int j;
    int tmp;
    next_in = 1;
    while (order.size() < n) begin
      if (next_in <= n && (pile.size() == 0 || $urandom_range(1) == 1)) begin
        pile.insert(pile.size(), next_in);
        next_in++;
      end else begin
        order.insert(order.size(), pile.pop_back());
      end
    end
    roll = $urandom_range(99);
    if (roll < 70) begin
    end else if (roll < 76 && order.size() > 1) begin
      i = $urandom_range(order.size() - 1);
      j = $urandom_range(order.size() - 1);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end else if (roll < 82 && order.size() > 1) begin
      repeat ($urandom_range(1, order.size() - 1)) order.delete(order.size() - 1);
    end else if (roll < 87) begin
      order.insert(order.size(), $urandom_range(1, n + 1));
    end else if (roll < 93) begin
      order[$urandom_range(order.size() - 1)] = $urandom_range(spc_pkg::CAR_MAX);
    end else begin
      order.delete();
      repeat ($urandom_range(1, n + 2)) begin
        order.insert(order.size(), ($urandom_range(1) == 1) ? $urandom_range(spc_pkg::CAR_MAX)
                                                             : $urandom_range(n + 1));
      end
    end
    foreach (order[k]) queue_car(order[k], k == order.size() - 1);
  endtask

  task automatic run_phase(input int n, input int idle, input int stall, input int target,
                           input bit squeeze);
    int start;
    wait_idle();
    set_cars(spc_pkg::CAR_W'(n));
    idle_pct = idle;
    stall_pct = stall;
    if (squeeze) pressure_go = 1'b1;
    start = cars_sent;
    while (cars_sent - start < target) add_sequence(n);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    // At the reset length of 1024 cars.
    queue_car(0, 0);
    queue_car(5, 1);
    queue_car(spc_pkg::CAR_MAX, 1);
    queue_car(1024, 0);
    queue_car(1023, 1);

    wait_idle();
    set_cars(1);
    queue_car(1, 1);
    queue_car(1, 0);
    queue_car(1, 1);

    wait_idle();
    set_cars(3);
    queue_car(3, 0);
    queue_car(1, 0);
    queue_car(2, 1);
    queue_car(3, 0);
    queue_car(2, 0);
    queue_car(1, 1);
    queue_car(1, 0);
    queue_car(2, 1);
    queue_car(4, 1);

    wait_idle();
    set_cars(0);
    queue_car(1, 1);

    wait_idle();
    set_cars(spc_pkg::CAR_W'(spc_pkg::CAR_MAX));
    queue_car(1025, 1);
    queue_car(2, 1);

    // The length changes while a sequence is still open.
    wait_idle();
    set_cars(2);
    queue_car(2, 0);
    wait_idle();
    set_cars(3);
    queue_car(1, 0);
    queue_car(3, 1);

    run_phase(6, 0, 0, 230, 1'b0);
    run_phase(2, 50, 0, 150, 1'b0);
    run_phase(12, 0, 50, 250, 1'b0);
    run_phase(5, 27, 27, 250, 1'b0);
    run_phase(3, 0, 0, 100, 1'b1);
    run_phase(40, 27, 27, 150, 1'b0);

    wait_idle();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
